[design/jsu_pkg.sv]
// jsu_pkg: shared types, codes and character helpers for the json string unescaper
`timescale 1ns / 1ps
package jsu_pkg;

  // parse phase
  typedef enum logic [2:0] {
    PH_QUOTE  = 3'd0,
    PH_STRING = 3'd1,
    PH_ESCAPE = 3'd2,
    PH_HEX    = 3'd3,
    PH_HEXBAD = 3'd4
  } phase_t;

  // result status codes
  localparam logic [2:0] ST_DATA    = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_NOQUOTE = 3'd2;
  localparam logic [2:0] ST_BADESC  = 3'd3;
  localparam logic [2:0] ST_BADUNI  = 3'd4;
  localparam logic [2:0] ST_UNTERM  = 3'd5;

  // configuration register indexes
  localparam logic CFG_EXPECT_QUOTE = 1'b0;
  localparam logic CFG_DECODE_EN    = 1'b1;

  // characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  hex_cnt;
    logic [15:0] code_point;
  } parse_state_t;

  // results caused by one input byte, entry 0 first
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] data;
    logic [2:0][2:0] status;
  } result_grp_t;

  // whitespace skipped before the opening quote
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // {valid, mapped byte} for single-letter escapes
  function automatic logic [8:0] escape_map(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h62:   r = {1'b1, 8'h08};
      8'h74:   r = {1'b1, 8'h09};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h66:   r = {1'b1, 8'h0C};
      8'h72:   r = {1'b1, 8'h0D};
      8'h22:   r = {1'b1, 8'h22};
      8'h2F:   r = {1'b1, 8'h2F};
      8'h5C:   r = {1'b1, 8'h5C};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

[design/jsu_parse.sv]
// jsu_parse: next-state and result logic for one raw byte
`timescale 1ns / 1ps
module jsu_parse (
  input  logic                 expect_quote,
  input  logic                 decode_en,
  input  logic [7:0]           c,
  input  logic                 eos,
  input  jsu_pkg::parse_state_t cur,
  output jsu_pkg::parse_state_t nxt,
  output jsu_pkg::result_grp_t  grp
);
  import jsu_pkg::*;

  always_comb begin
    parse_state_t idle_st;
    logic [4:0]   hv;
    logic [8:0]   em;
    logic [15:0]  cp_new;
    phase_t       ph_new;

    idle_st.phase      = expect_quote ? PH_QUOTE : PH_STRING;
    idle_st.hex_cnt    = 2'd0;
    idle_st.code_point = 16'd0;
    hv     = hex_value(c);
    em     = escape_map(c);
    cp_new = {cur.code_point[11:0], hv[3:0]};
    ph_new = (!hv[4] && decode_en) ? PH_HEXBAD : cur.phase;

    nxt = cur;
    grp = '0;

    case (cur.phase)
      // inside the string
      PH_STRING: begin
        if (eos) begin
          grp.cnt = 2'd1; grp.status[0] = ST_UNTERM; nxt = idle_st;
        end else if (c == CH_BSLASH) begin
          nxt.phase = PH_ESCAPE;
        end else if (c == CH_QUOTE) begin
          grp.cnt = 2'd1; grp.status[0] = ST_DONE; nxt = idle_st;
        end else if (decode_en) begin
          grp.cnt = 2'd1; grp.data[0] = c; grp.status[0] = ST_DATA;
        end
      end
      // letter after a backslash
      PH_ESCAPE: begin
        if (eos) begin
          grp.cnt = 2'd1; grp.status[0] = ST_UNTERM; nxt = idle_st;
        end else if (c == CH_U) begin
          nxt.phase = PH_HEX; nxt.hex_cnt = 2'd0; nxt.code_point = 16'd0;
        end else if (!em[8]) begin
          grp.cnt = 2'd1; grp.status[0] = ST_BADESC; nxt = idle_st;
        end else begin
          if (decode_en) begin
            grp.cnt = 2'd1; grp.data[0] = em[7:0]; grp.status[0] = ST_DATA;
          end
          nxt.phase = PH_STRING;
        end
      end
      // four digits after \u
      PH_HEX, PH_HEXBAD: begin
        if (eos) begin
          grp.cnt = 2'd1; grp.status[0] = ST_BADUNI; nxt = idle_st;
        end else if (cur.hex_cnt != 2'd3) begin
          nxt.phase      = ph_new;
          nxt.hex_cnt    = cur.hex_cnt + 2'd1;
          nxt.code_point = cp_new;
        end else if (ph_new == PH_HEXBAD) begin
          grp.cnt = 2'd1; grp.status[0] = ST_BADUNI; nxt = idle_st;
        end else begin
          if (decode_en) begin
            if (cp_new < 16'h0080) begin
              grp.cnt = 2'd1;
              grp.data[0] = cp_new[7:0];
            end else if (cp_new < 16'h0800) begin
              grp.cnt = 2'd2;
              grp.data[0] = {3'b110, cp_new[10:6]};
              grp.data[1] = {2'b10, cp_new[5:0]};
            end else begin
              grp.cnt = 2'd3;
              grp.data[0] = {4'b1110, cp_new[15:12]};
              grp.data[1] = {2'b10, cp_new[11:6]};
              grp.data[2] = {2'b10, cp_new[5:0]};
            end
          end
          nxt.phase = PH_STRING; nxt.hex_cnt = 2'd0; nxt.code_point = 16'd0;
        end
      end
      // awaiting opening quote, also unused codes
      default: begin
        if (eos) begin
          grp.cnt = 2'd1; grp.status[0] = ST_NOQUOTE; nxt = idle_st;
        end else if (is_space(c)) begin
          nxt = cur;
        end else if (c == CH_QUOTE) begin
          nxt.phase = PH_STRING; nxt.hex_cnt = 2'd0; nxt.code_point = 16'd0;
        end else begin
          grp.cnt = 2'd1; grp.status[0] = ST_NOQUOTE; nxt = idle_st;
        end
      end
    endcase
  end

endmodule

[design/json_string_unescape.sv]
// json_string_unescape: top level, input register, parse state and result buffer
// An input beat passes through the input register and then the result buffer before its first result beat.
// One input byte is taken per cycle while the result buffer is free; a \u escape yielding 2 or 3 UTF-8 bytes
// holds the input side while the result buffer drains.
// Results leave one beat per cycle while out_tready is high, from a 3-entry result buffer.
// Reset (rst_n low, synchronous): buffers empty, expect_open_quote = 1,
// decode_enable = 1, parser awaiting the opening quote.
`timescale 1ns / 1ps
module json_string_unescape (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_stream
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [2:0] status
  output logic       out_tlast,  // last
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_addr,
  input  logic       cfg_wr_data
);
  import jsu_pkg::*;

  logic         in_vld_r;
  logic [7:0]   in_byte_r;
  logic         in_eos_r;
  logic         expect_r;
  logic         decode_r;
  parse_state_t st_r, st_nxt, st_step;
  result_grp_t  grp_r, grp_nxt, grp_step;
  logic         out_fire;
  logic         grp_free;
  logic         step;

  // handshake
  assign out_fire  = out_tvalid && out_tready;
  assign grp_free  = (grp_r.cnt == 2'd0) || ((grp_r.cnt == 2'd1) && out_fire);
  assign step      = in_vld_r && grp_free;
  assign in_tready = !in_vld_r || step;

  assign out_tvalid = grp_r.cnt != 2'd0;
  assign out_tdata  = grp_r.data[0];
  assign out_tuser  = grp_r.status[0];
  assign out_tlast  = grp_r.cnt == 2'd1;

  jsu_parse u_parse (
    .expect_quote (expect_r),
    .decode_en    (decode_r),
    .c            (in_byte_r),
    .eos          (in_eos_r),
    .cur          (st_r),
    .nxt          (st_step),
    .grp          (grp_step)
  );

  // parser state, restarted by a register write
  always_comb begin
    st_nxt = st_r;
    if (cfg_wr_en) begin
      st_nxt.hex_cnt    = 2'd0;
      st_nxt.code_point = 16'd0;
      if (cfg_addr == CFG_EXPECT_QUOTE) begin
        st_nxt.phase = cfg_wr_data ? PH_QUOTE : PH_STRING;
      end else begin
        st_nxt.phase = expect_r ? PH_QUOTE : PH_STRING;
      end
    end else if (step) begin
      st_nxt = st_step;
    end
  end

  // result buffer: load a new group or shift out the head
  always_comb begin
    grp_nxt = grp_r;
    if (step) begin
      grp_nxt = grp_step;
    end else if (out_fire) begin
      grp_nxt.cnt       = grp_r.cnt - 2'd1;
      grp_nxt.data[0]   = grp_r.data[1];
      grp_nxt.data[1]   = grp_r.data[2];
      grp_nxt.status[0] = grp_r.status[1];
      grp_nxt.status[1] = grp_r.status[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      expect_r   <= 1'b1;
      decode_r   <= 1'b1;
      st_r       <= '{phase: PH_QUOTE, hex_cnt: 2'd0, code_point: 16'd0};
      grp_r      <= '0;
    end else begin
      if (in_tready) in_vld_r <= in_tvalid;
      if (cfg_wr_en && cfg_addr == CFG_EXPECT_QUOTE) expect_r <= cfg_wr_data;
      if (cfg_wr_en && cfg_addr == CFG_DECODE_EN) decode_r <= cfg_wr_data;
      st_r  <= st_nxt;
      grp_r <= grp_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_eos_r  <= in_tlast;
    end
  end

  // a held input byte blocks the input side only while the buffer is busy
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_vld_r && !grp_free))
    else $error("input stalled without a pending byte");

  // the final beat of a group empties the buffer unless a new byte steps in
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_tlast && !step) |=> (grp_r.cnt == 2'd0))
    else $error("result buffer not empty after last beat");

  // only data beats carry a byte
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_DATA) |-> (out_tdata == 8'd0 && out_tlast))
    else $error("status beat carries data or is not last");

  // a register write restarts the hex gathering
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (st_r.hex_cnt == 2'd0 && st_r.code_point == 16'd0))
    else $error("parser not restarted by register write");

endmodule

[tb/json_unescape_checker.sv]
// json_unescape_checker: predicts the unescaper results and compares every result beat
`timescale 1ns / 1ps
module json_unescape_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_stream
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [7:0] out_byte
  input  logic [2:0] out_tuser,  // [2:0] status
  input  logic       out_tlast,
  input  logic       cfg_wr_en,
  input  logic       cfg_addr,
  input  logic       cfg_wr_data,
  output int         fail_count,
  output int         pending,
  output int         checked_beats,
  output int         error_beats
);
  import jsu_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] status;
    logic       last;
  } result_t;

  // parser copy and register copy
  phase_t      ph;
  logic [1:0]  hex_n;
  logic [15:0] cp;
  logic        quote_mode;
  logic        decode_on;

  result_t     decoded_q[$];
  result_t     want;

  task automatic report(input string what, input int got, input int exp_val);
    if (fail_count < 30)
      $display("%0t mismatch on %s: got 0x%0h, wanted 0x%0h", $time, what, got, exp_val);
    fail_count++;
  endtask

  task automatic to_idle();
    ph = quote_mode ? PH_QUOTE : PH_STRING;
    hex_n = 2'd0;
    cp = 16'h0000;
  endtask

  function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
    v = 4'h0;
    if (c >= "0" && c <= "9") v = 4'(c - "0");
    else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit unescaped(input logic [7:0] c, output logic [7:0] b);
    b = c;
    case (c)
      "b":       b = 8'h08;
      "t":       b = 8'h09;
      "n":       b = 8'h0A;
      "f":       b = 8'h0C;
      "r":       b = 8'h0D;
      CH_QUOTE, "/", CH_BSLASH: b = c;
      default:   return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // work out the results of one input beat and queue them in order
  task automatic decode_beat(input logic [7:0] c, input logic eos);
    result_t     res [3];
    result_t     r;
    int          n;
    logic [3:0]  nib;
    logic [7:0]  mapped;
    n = 0;
    case (ph)
      PH_STRING: begin
        if (eos) begin
          res[n] = {8'h00, ST_UNTERM, 1'b0}; n++;
          to_idle();
        end else if (c == CH_BSLASH) begin
          ph = PH_ESCAPE;
        end else if (c == CH_QUOTE) begin
          res[n] = {8'h00, ST_DONE, 1'b0}; n++;
          to_idle();
        end else if (decode_on) begin
          res[n] = {c, ST_DATA, 1'b0}; n++;
        end
      end
      PH_ESCAPE: begin
        if (eos) begin
          res[n] = {8'h00, ST_UNTERM, 1'b0}; n++;
          to_idle();
        end else if (c == CH_U) begin
          ph = PH_HEX;
          hex_n = 2'd0;
          cp = 16'h0000;
        end else if (!unescaped(c, mapped)) begin
          res[n] = {8'h00, ST_BADESC, 1'b0}; n++;
          to_idle();
        end else begin
          if (decode_on) begin
            res[n] = {mapped, ST_DATA, 1'b0}; n++;
          end
          ph = PH_STRING;
        end
      end
      PH_HEX, PH_HEXBAD: begin
        if (eos) begin
          res[n] = {8'h00, ST_BADUNI, 1'b0}; n++;
          to_idle();
        end else begin
          // a bad digit counts as zero and is flagged only when decoding
          if (!hex_digit(c, nib) && decode_on) ph = PH_HEXBAD;
          cp = {cp[11:0], nib};
          if (hex_n != 2'd3) begin
            hex_n = hex_n + 2'd1;
          end else if (ph == PH_HEXBAD) begin
            res[n] = {8'h00, ST_BADUNI, 1'b0}; n++;
            to_idle();
          end else begin
            // utf-8 encoding of the gathered code point
            if (decode_on) begin
              if (cp < 16'h0080) begin
                res[n] = {cp[7:0], ST_DATA, 1'b0}; n++;
              end else if (cp < 16'h0800) begin
                res[n] = {{3'b110, cp[10:6]}, ST_DATA, 1'b0}; n++;
                res[n] = {{2'b10, cp[5:0]}, ST_DATA, 1'b0}; n++;
              end else begin
                res[n] = {{4'b1110, cp[15:12]}, ST_DATA, 1'b0}; n++;
                res[n] = {{2'b10, cp[11:6]}, ST_DATA, 1'b0}; n++;
                res[n] = {{2'b10, cp[5:0]}, ST_DATA, 1'b0}; n++;
              end
            end
            ph = PH_STRING;
            hex_n = 2'd0;
            cp = 16'h0000;
          end
        end
      end
      default: begin
        if (eos) begin
          res[n] = {8'h00, ST_NOQUOTE, 1'b0}; n++;
          to_idle();
        end else if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D)) begin
          // whitespace before the opening quote is skipped
        end else if (c == CH_QUOTE) begin
          ph = PH_STRING;
          hex_n = 2'd0;
          cp = 16'h0000;
        end else begin
          res[n] = {8'h00, ST_NOQUOTE, 1'b0}; n++;
          to_idle();
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      r = res[i];
      r.last = (i == n - 1);
      decoded_q = {decoded_q, r};
    end
  endtask

  // result beats are compared before the same edge's input beat is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      quote_mode = 1'b1;
      decode_on = 1'b1;
      to_idle();
      decoded_q.delete();
      fail_count = 0;
      checked_beats = 0;
      error_beats = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        checked_beats++;
        if (out_tuser >= ST_NOQUOTE) error_beats++;
        if (decoded_q.size() == 0) begin
          report("unexpected result beat, status", out_tuser, 0);
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata !== want.data) report("out_byte", out_tdata, want.data);
          if (out_tuser !== want.status) report("status", out_tuser, want.status);
          if (out_tlast !== want.last) report("last", out_tlast, want.last);
        end
      end
      if (cfg_wr_en) begin
        if (cfg_addr == CFG_EXPECT_QUOTE) quote_mode = cfg_wr_data;
        else decode_on = cfg_wr_data;
        to_idle();
      end
      if (in_tvalid && in_tready) decode_beat(in_tdata, in_tlast);
    end
    pending = decoded_q.size();
  end

endmodule

[tb/testbench.sv]
// testbench: stimulus, idling, watchdog and verdict for the json string unescaper
`timescale 1ns / 1ps
module testbench;
  import jsu_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;    // [7:0] in_byte
  logic       in_tlast = 1'b0;     // end_of_stream
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_byte
  logic [2:0] out_tuser;           // [2:0] status
  logic       out_tlast;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_addr = 1'b0;
  logic       cfg_wr_data = 1'b0;

  int fail_count;
  int pending;
  int checked_beats;
  int error_beats;

  // stimulus bookkeeping
  bit   cfg_quote = 1'b1;
  bit   cfg_decode = 1'b1;
  bit   steady = 1'b0;
  int   burst_left = 0;
  int   items_sent = 0;
  int   strings_sent = 0;
  int   unicode_sent = 0;
  int   quiet_cycles = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  logic [3:0]  stall_idx = 4'd0;

  logic [7:0]  esc_letters [8] = '{"b", "t", "n", "f", "r", CH_QUOTE, "/", CH_BSLASH};
  logic [15:0] boundary_cp [7] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                   16'h0800, 16'hFFFF, 16'hD83D};

  json_string_unescape uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  json_unescape_checker unescape_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_beats (checked_beats),
    .error_beats   (error_beats)
  );

  always #10 clk = ~clk;

  // receiver stalls on a 16-bit pattern that is drawn anew every pass
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_idx <= 4'd0;
    end else begin
      out_tready <= steady | stall_pat[stall_idx];
      stall_idx <= stall_idx + 4'd1;
      if (stall_idx == 4'd15) begin
        case ($urandom_range(0, 3))
          0:       stall_pat <= 16'hFFFF;
          1:       stall_pat <= 16'($urandom | $urandom);
          2:       stall_pat <= 16'($urandom) | 16'h0001;
          default: stall_pat <= 16'($urandom & $urandom) | 16'h0001;
        endcase
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results pending", quiet_cycles, pending);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic bit is_hex(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return "0" + 8'(nib);
    return (upper ? "A" : "a") + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(0, 5))
      0:       return boundary_cp[$urandom_range(0, 6)];
      1:       return 16'($urandom_range(0, 16'h007F));
      2:       return 16'($urandom_range(16'h0080, 16'h07FF));
      default: return 16'($urandom_range(16'h0800, 16'hFFFF));
    endcase
  endfunction

  // one input beat, opening a new burst with a random gap when the last one ran out
  task automatic send_beat(input logic [7:0] b, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eos;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat(b, 1'b0);
  endtask

  task automatic send_eos();
    send_beat(8'($urandom), 1'b1);
  endtask

  // backslash-u escape, optionally with a non-hex digit or an early end of stream
  task automatic send_unicode(input logic [15:0] cp, input int bad_at, input int eos_at);
    logic [7:0] b;
    send_byte(CH_BSLASH);
    send_byte(CH_U);
    unicode_sent++;
    for (int i = 0; i < 4; i++) begin
      if (i == eos_at) begin
        send_eos();
        return;
      end
      b = hex_char(4'(cp >> (12 - 4 * i)), $urandom_range(0, 1));
      if (i == bad_at) begin
        b = 8'($urandom);
        if (is_hex(b)) b = "g";
      end
      send_byte(b);
    end
  endtask

  // mostly well-formed strings with random content, some broken on purpose
  task automatic send_string();
    int         n_tok;
    int         kind;
    logic [7:0] b;
    strings_sent++;
    if (cfg_quote) begin
      repeat ($urandom_range(0, 2)) begin
        b = 8'($urandom_range(0, 5));
        send_byte(b == 8'd5 ? CH_SPACE : 8'h09 + b);
      end
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
        send_eos();
        return;
      end
      if (kind == 1) begin
        b = 8'($urandom);
        if (is_blank(b) || b == CH_QUOTE) b = "x";
        send_byte(b);
        return;
      end
      send_byte(CH_QUOTE);
    end
    n_tok = $urandom_range(0, 8);
    for (int i = 0; i < n_tok; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        b = 8'($urandom);
        if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
        send_byte(b);
      end else if (kind < 65) begin
        send_byte(CH_BSLASH);
        send_byte(esc_letters[$urandom_range(0, 7)]);
      end else if (kind < 85) begin
        send_unicode(pick_code_point(), -1, -1);
      end else if (kind < 89) begin
        // unknown escape letter
        b = 8'($urandom);
        case (b)
          "b", "t", "n", "f", "r", "u", "/", CH_QUOTE, CH_BSLASH: b = "q";
          default: ;
        endcase
        send_byte(CH_BSLASH);
        send_byte(b);
        return;
      end else if (kind < 93) begin
        send_unicode(pick_code_point(), $urandom_range(0, 3), -1);
        if (cfg_decode) return;
      end else if (kind < 95) begin
        send_eos();
        return;
      end else if (kind < 97) begin
        send_byte(CH_BSLASH);
        send_eos();
        return;
      end else begin
        send_unicode(pick_code_point(), -1, $urandom_range(0, 3));
        return;
      end
    end
    if ($urandom_range(0, 9) == 0) send_eos();
    else send_byte(CH_QUOTE);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send_beat(8'($urandom), $urandom_range(0, 15) == 0);
  endtask

  // hold the sender until every predicted result has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // idle the block, then write both registers
  task automatic apply_setting(input bit quote_on, input bit decode_on);
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= CFG_EXPECT_QUOTE;
    cfg_wr_data <= quote_on;
    @(posedge clk);
    cfg_addr <= CFG_DECODE_EN;
    cfg_wr_data <= decode_on;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_quote = quote_on;
    cfg_decode = decode_on;
  endtask

  task automatic run_strings(input int target);
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_string();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    apply_setting(1'b1, 1'b1);

    // directed: whitespace, extremes, escapes, utf-8 lengths, missing quote
    send_byte(8'h09);
    send_byte(8'h0D);
    send_byte(CH_SPACE);
    send_byte(CH_QUOTE);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_BSLASH);
    send_byte("n");
    send_byte(CH_BSLASH);
    send_byte(CH_BSLASH);
    send_unicode(16'h07FF, -1, -1);
    send_unicode(16'hFFFF, -1, -1);
    send_byte(CH_QUOTE);
    send_byte("x");
    send_eos();
    drain();

    // random strings over the register settings
    run_strings(140);
    drain();
    run_strings(220);
    apply_setting(1'b0, 1'b1);
    run_strings(290);
    apply_setting(1'b1, 1'b0);
    run_strings(340);
    apply_setting(1'b0, 1'b0);
    steady = 1'b1;
    run_strings(385);
    steady = 1'b0;
    apply_setting(1'b1, 1'b1);
    run_strings(430);

    drain();
    repeat (8) @(posedge clk);
    $display("sent %0d input beats in %0d strings (%0d unicode escapes), five register settings",
             items_sent, strings_sent, unicode_sent);
    $display("checked %0d result beats, %0d of them error reports", checked_beats, error_beats);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/jsu_pkg.sv
design/jsu_parse.sv
design/json_string_unescape.sv
tb/json_unescape_checker.sv
tb/testbench.sv
